@@ design/mcfir_pkg.sv @@
// Shared types and constants of the multichannel FIR filter.
`default_nettype none

package mcfir_pkg;

    localparam int unsigned SAMPLE_W = 32;
    localparam int unsigned ACC_W    = 48;
    localparam int unsigned SHIFT_R  = 23;
    localparam logic [55:0] ROUND_K  = 56'h40_0000;

    typedef enum logic {
        ACT_COEF   = 1'b0,
        ACT_FILTER = 1'b1
    } t_action;

    typedef struct packed {
        logic                       action;
        logic [2:0]                 channel;
        logic [4:0]                 tap;
        logic signed [SAMPLE_W-1:0] coeff_value;
        logic signed [SAMPLE_W-1:0] sample;
    } t_in_item;

    typedef struct packed {
        logic [2:0]                 out_channel;
        logic signed [SAMPLE_W-1:0] filtered;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_PTR,
        ST_MAC,
        ST_DRAIN,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic clr;
        logic load_item;
        logic wr_coef;
        logic rd_ptr;
        logic shift;
        logic mac_issue;
        logic load_out;
    } t_fir_cmd;

    typedef struct packed {
        logic clr_last;
        logic is_filter;
        logic ch_ok;
        logic tap_ok;
        logic issue_last;
        logic pipe_busy;
        logic out_free;
    } t_fir_sts;

endpackage

`default_nettype wire

@@ design/mcfir_ctrl.sv @@
// Sequencer of the multichannel FIR filter: clear sweep, decode, MAC loop, output.
`default_nettype none

module mcfir_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  mcfir_pkg::t_fir_sts  i_sts,
    output mcfir_pkg::t_fir_cmd  o_cmd
);
    import mcfir_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (!i_sts.ch_ok) begin
                    n_state = ST_IDLE;
                end else if (i_sts.is_filter) begin
                    o_cmd.rd_ptr = 1'b1;
                    n_state      = ST_PTR;
                end else begin
                    o_cmd.wr_coef = i_sts.tap_ok;
                    n_state       = ST_IDLE;
                end
            end
            ST_PTR: begin
                o_cmd.shift = 1'b1;
                n_state     = ST_MAC;
            end
            ST_MAC: begin
                o_cmd.mac_issue = 1'b1;
                if (i_sts.issue_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ design/mcfir_dp.sv @@
// Datapath of the multichannel FIR filter: memories, circular delay lines, MAC, output register.
`default_nettype none

module mcfir_dp #(
    parameter int CHANNELS = 8,
    parameter int TAPS     = 32
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  mcfir_pkg::t_in_item   i_in_item,
    input  wire                   i_out_stall,
    output logic                  o_out_valid,
    output mcfir_pkg::t_out_item  o_out_item,
    input  mcfir_pkg::t_fir_cmd   i_cmd,
    output mcfir_pkg::t_fir_sts   o_sts
);
    import mcfir_pkg::*;

    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int TAP_W  = $clog2(TAPS);
    localparam int ADDR_W = CH_W + TAP_W;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam int NCH    = 1 << CH_W;

    // item under work
    t_in_item r_item;

    logic [CH_W+2:0]   ch_ext;
    logic [TAP_W+4:0]  tap_ext;
    logic [CH_W-1:0]   ch_idx;
    logic [TAP_W-1:0]  tap_idx;

    // memories: coefficient and delay address is {channel, tap}, head pointer address is channel
    logic [SAMPLE_W-1:0] r_coef_mem [DEPTH];
    logic [SAMPLE_W-1:0] r_dly_mem  [DEPTH];
    logic [TAP_W-1:0]    r_ptr_mem  [NCH];

    logic [ADDR_W-1:0]   r_clr_addr;
    logic [TAP_W-1:0]    r_head;
    logic [TAP_W-1:0]    new_head;
    logic [TAP_W-1:0]    r_idx;
    logic [TAP_W-1:0]    r_cnt;

    logic [SAMPLE_W-1:0] r_coef_q;
    logic [SAMPLE_W-1:0] r_dly_q;
    logic signed [63:0]  r_prod;
    logic [ACC_W-1:0]    r_acc;
    logic                r_rd_v;
    logic                r_mul_v;

    logic [55:0]         rnd;
    logic                r_out_valid;
    t_out_item           r_out_item;

    assign ch_ext  = {{CH_W{1'b0}}, r_item.channel};
    assign tap_ext = {{TAP_W{1'b0}}, r_item.tap};
    assign ch_idx  = ch_ext[CH_W-1:0];
    assign tap_idx = tap_ext[TAP_W-1:0];

    // newest sample goes one slot below the old head
    assign new_head = (r_head == '0) ? TAP_W'(TAPS - 1) : r_head - 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // coefficient memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            r_coef_mem[r_clr_addr] <= '0;
        end else if (i_cmd.wr_coef) begin
            r_coef_mem[{ch_idx, tap_idx}] <= r_item.coeff_value;
        end
        if (i_cmd.mac_issue) begin
            r_coef_q <= r_coef_mem[{ch_idx, r_cnt}];
        end
    end

    // delay line memory, circular per channel
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            r_dly_mem[r_clr_addr] <= '0;
        end else if (i_cmd.shift) begin
            r_dly_mem[{ch_idx, new_head}] <= r_item.sample;
        end
        if (i_cmd.mac_issue) begin
            r_dly_q <= r_dly_mem[{ch_idx, r_idx}];
        end
    end

    // head pointer memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            r_ptr_mem[r_clr_addr[CH_W-1:0]] <= '0;
        end else if (i_cmd.shift) begin
            r_ptr_mem[ch_idx] <= new_head;
        end
        if (i_cmd.rd_ptr) begin
            r_head <= r_ptr_mem[ch_idx];
        end
    end

    // tap walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_cnt <= '0;
        end else if (i_cmd.shift) begin
            r_idx <= new_head;
            r_cnt <= '0;
        end else if (i_cmd.mac_issue) begin
            r_idx <= (r_idx == TAP_W'(TAPS - 1)) ? '0 : r_idx + 1'b1;
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // read -> multiply -> accumulate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v  <= 1'b0;
            r_mul_v <= 1'b0;
        end else begin
            r_rd_v  <= i_cmd.mac_issue;
            r_mul_v <= r_rd_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_v) begin
            r_prod <= $signed(r_coef_q) * $signed(r_dly_q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.shift) begin
            r_acc <= '0;
        end else if (r_mul_v) begin
            r_acc <= r_acc + r_prod[ACC_W-1:0];
        end
    end

    // round and scale
    assign rnd = {{(56 - ACC_W){r_acc[ACC_W-1]}}, r_acc} + ROUND_K;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_item.out_channel <= r_item.channel;
            r_out_item.filtered    <= rnd[SHIFT_R+SAMPLE_W-1:SHIFT_R];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_comb begin
        o_sts            = '0;
        o_sts.clr_last   = &r_clr_addr;
        o_sts.is_filter  = (r_item.action == ACT_FILTER);
        o_sts.ch_ok      = (ch_ext < (CH_W + 3)'(CHANNELS));
        o_sts.tap_ok     = (tap_ext < (TAP_W + 5)'(TAPS));
        o_sts.issue_last = (r_cnt == TAP_W'(TAPS - 1));
        o_sts.pipe_busy  = r_rd_v | r_mul_v;
        o_sts.out_free   = !r_out_valid || !i_out_stall;
    end

endmodule

`default_nettype wire

@@ design/multichannel_fir_filter_unit.sv @@
// One item is taken at a time; input stalls until it is done. A filter item's run is
// set by the one shared multiply-accumulate that walks the channel's taps one per cycle.
// Its result follows the pointer read, sample write, MAC loop, drain and output load.
// The output register lets the next item in while a result still waits to be taken.
// Reset (i_rst_n low, synchronous) starts a clearing pass, with input stalled, that zeroes
// coefficients and delay lines, 2^(clog2(CHANNELS)+clog2(TAPS)) addresses (256 by default).
`default_nettype none

module multichannel_fir_filter_unit #(
    parameter int CHANNELS = 8,
    parameter int TAPS     = 32
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    // input channel
    input  wire                   i_in_valid,
    output logic                  o_in_stall,
    input  mcfir_pkg::t_in_item   i_in_item,
    // output channel
    output logic                  o_out_valid,
    input  wire                   i_out_stall,
    output mcfir_pkg::t_out_item  o_out_item
);
    import mcfir_pkg::*;

    // command and status between sequencer and datapath
    t_fir_cmd cmd;
    t_fir_sts sts;

    // Sequencer: owns the state, decides when memories are touched and
    // when the MAC loop starts and ends.
    mcfir_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Datapath: coefficient and delay memories (circular buffer per channel,
    // newest sample at the head), 32x32 multiplier, 48-bit wrapping
    // accumulator, round-and-shift, output register.
    mcfir_dp #(
        .CHANNELS (CHANNELS),
        .TAPS     (TAPS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule

`default_nettype wire

@@ design/mcfir_chk.sv @@
// Port-level checker for the multichannel FIR filter and its bind.
`default_nettype none

module mcfir_chk (
    input wire                   i_clk,
    input wire                   i_rst_n,
    input wire                   i_in_valid,
    input wire                   o_in_stall,
    input wire                   o_out_valid,
    input wire                   i_out_stall,
    input mcfir_pkg::t_out_item  o_out_item
);

    // a result waiting on the receiver stays
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output item dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_item))
        else $error("output item changed while stalled");

    // reset starts the clearing pass, which holds off input items
    a_clear_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("input not stalled after reset");

    // one item at a time: stall follows every accepted item
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second item taken while busy");

    // a new result is only produced while the block is busy
    a_out_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a filter item in work");

endmodule

bind multichannel_fir_filter_unit mcfir_chk u_mcfir_chk (.*);

`default_nettype wire
